// ===== src/cerl_pkg.sv =====
package cerl_pkg;

  localparam int unsigned MAX_COLS_DEF        = 4096;
  localparam int unsigned LOGIT_BITS_DEF      = 16;
  localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

  localparam int unsigned OP_QUEUE_DEPTH  = 4;
  localparam int unsigned OUT_QUEUE_DEPTH = 2;

  localparam int unsigned TARGET_W = 16;
  localparam int unsigned LOSS_W   = 25;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TERM_W   = 17;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned LN_TAB_W = 16;
  localparam int unsigned LN_W     = 20;

  localparam logic [TERM_W-1:0] Q16_ONE = 17'h10000;
  localparam logic [LN_W-1:0]   LN2_Q16 = 20'd45426;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_RESCALE,
    OP_ACCUM,
    OP_SKIP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_TARGET = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    op_t     op;
    logic    last;
    status_t status;
  } ctl_t;

  // restoring division, used only while building the tables
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-x), 0 <= x <= 1, Q30 in and out
  function automatic longint unsigned exp_neg_q30(input longint unsigned x);
    longint unsigned t;
    longint          acc;
    t   = Q30_ONE;
    acc = longint'(Q30_ONE);
    for (int unsigned i = 1; i <= 20; i++) begin
      t = udiv64((t * x) >> 30, longint'(i));
      if (i[0]) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return longint'(acc);
  endfunction

  function automatic logic [TERM_W-1:0] iexp_entry(input int unsigned n);
    longint unsigned e1;
    longint unsigned v;
    e1 = exp_neg_q30(Q30_ONE);
    v  = Q30_ONE;
    for (int unsigned m = 0; m < n; m++) begin
      v = (v * e1 + (64'd1 << 29)) >> 30;
    end
    return TERM_W'((v + (64'd1 << 13)) >> 14);
  endfunction

  function automatic logic [TERM_W-1:0] fexp_entry(input int unsigned k,
                                                   input int unsigned depth);
    longint unsigned x;
    x = udiv64(longint'(k) << 30, longint'(depth));
    return TERM_W'((exp_neg_q30(x) + (64'd1 << 13)) >> 14);
  endfunction

  // ln(1 + j/256) in Q16 by atanh series
  function automatic logic [LN_TAB_W-1:0] ln_entry(input int unsigned j);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned acc;
    z   = udiv64(longint'(j) << 30, longint'(512 + j));
    z2  = (z * z) >> 30;
    p   = z;
    acc = 64'd0;
    for (int unsigned m = 0; m < 16; m++) begin
      acc = acc + udiv64(p, longint'(2 * m + 1));
      p   = (p * z2) >> 30;
    end
    return LN_TAB_W'((2 * acc + (64'd1 << 13)) >> 14);
  endfunction

endpackage

// ===== src/cross_entropy_row_loss_core.sv =====
// Streaming softmax cross-entropy loss, one row at a time. Push one logit per
// item (signed Q7.8) with the row's target class (taken from the row's first
// item) and a last-in-row mark; one result item (loss in unsigned Q9.16, and a
// status) comes out per row. The block sustains one item per clock while the
// result queue has room: the front end updates the running maximum, target
// capture and column count per item, and the back end closes the running-sum
// multiply-accumulate loop behind a registered exp-table product. A row's
// result passes through back-end registers s1 to s4 into the result queue.
// A 4-item queue sits between front and back, and a 2-item result queue lets
// results wait while new items keep coming. Status 1 means the target class
// lies outside the row, status 2 that the row had more than MAX_COLS items
// (extra items are ignored); the loss is then all ones.
module cross_entropy_row_loss_core #(
  parameter int unsigned MAX_COLS        = cerl_pkg::MAX_COLS_DEF,
  parameter int unsigned LOGIT_BITS      = cerl_pkg::LOGIT_BITS_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = cerl_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [LOGIT_BITS-1:0]         in_logit,
  input  logic [cerl_pkg::TARGET_W-1:0]        in_target_class,
  input  logic                                 in_last_in_row,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [cerl_pkg::LOSS_W-1:0]          out_loss,
  output logic [cerl_pkg::STATUS_W-1:0]        out_status
);

  localparam int unsigned CTL_W = $bits(cerl_pkg::ctl_t);
  localparam int unsigned OPQ_W = CTL_W + 2 * LOGIT_BITS;
  localparam int unsigned OQ_W  = cerl_pkg::STATUS_W + cerl_pkg::LOSS_W;

  logic                  accept;
  cerl_pkg::ctl_t        f_ctl;
  logic [LOGIT_BITS-1:0] f_d, f_diff;

  logic                  opq_full, opq_empty, opq_pop;
  logic [OPQ_W-1:0]      opq_rd;
  cerl_pkg::ctl_t        b_ctl;
  logic [LOGIT_BITS-1:0] b_d, b_diff;

  logic                        res_valid;
  logic [cerl_pkg::LOSS_W-1:0] res_loss;
  cerl_pkg::status_t           res_status;
  logic                        oq_full;
  logic [OQ_W-1:0]             oq_rd;

  assign accept  = in_push && !opq_full;
  assign in_full = opq_full;

  cerl_front #(
    .MAX_COLS   (MAX_COLS),
    .LOGIT_BITS (LOGIT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .logit        (in_logit),
    .target_class (in_target_class),
    .last_in_row  (in_last_in_row),
    .ctl          (f_ctl),
    .d            (f_d),
    .diff         (f_diff)
  );

  cerl_queue #(
    .WIDTH (OPQ_W),
    .DEPTH (cerl_pkg::OP_QUEUE_DEPTH)
  ) u_op_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept),
    .wr_data ({f_ctl, f_d, f_diff}),
    .full    (opq_full),
    .pop     (opq_pop),
    .rd_data (opq_rd),
    .empty   (opq_empty)
  );

  assign b_ctl  = cerl_pkg::ctl_t'(opq_rd[OPQ_W-1 -: CTL_W]);
  assign b_d    = opq_rd[LOGIT_BITS +: LOGIT_BITS];
  assign b_diff = opq_rd[LOGIT_BITS-1:0];

  cerl_back #(
    .LOGIT_BITS      (LOGIT_BITS),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (opq_empty),
    .q_ctl      (b_ctl),
    .q_d        (b_d),
    .q_diff     (b_diff),
    .q_pop      (opq_pop),
    .out_full   (oq_full),
    .res_valid  (res_valid),
    .res_loss   (res_loss),
    .res_status (res_status)
  );

  cerl_queue #(
    .WIDTH (OQ_W),
    .DEPTH (cerl_pkg::OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_valid),
    .wr_data ({res_status, res_loss}),
    .full    (oq_full),
    .pop     (out_pop),
    .rd_data (oq_rd),
    .empty   (out_empty)
  );

  assign out_loss   = oq_rd[cerl_pkg::LOSS_W-1:0];
  assign out_status = oq_rd[cerl_pkg::LOSS_W +: cerl_pkg::STATUS_W];

endmodule

// ===== src/cerl_queue.sv =====
module cerl_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty)) else $error("queue full and empty at once");

endmodule

// ===== src/cerl_front.sv =====
module cerl_front #(
  parameter int unsigned MAX_COLS   = cerl_pkg::MAX_COLS_DEF,
  parameter int unsigned LOGIT_BITS = cerl_pkg::LOGIT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic signed [LOGIT_BITS-1:0]        logit,
  input  logic [cerl_pkg::TARGET_W-1:0]       target_class,
  input  logic                                last_in_row,
  output cerl_pkg::ctl_t                      ctl,
  output logic [LOGIT_BITS-1:0]               d,
  output logic [LOGIT_BITS-1:0]               diff
);

  localparam int unsigned CNT_W = $clog2(MAX_COLS + 1);
  localparam int unsigned CMP_W = (CNT_W > cerl_pkg::TARGET_W) ? CNT_W : cerl_pkg::TARGET_W;
  localparam logic signed [LOGIT_BITS-1:0] MOST_NEG = {1'b1, {(LOGIT_BITS - 1){1'b0}}};

  logic signed [LOGIT_BITS-1:0]  max_r, max_nxt;
  logic signed [LOGIT_BITS-1:0]  tval_r, tval_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [cerl_pkg::TARGET_W-1:0] tgt_r, tgt_eff;
  logic                          seen_r, seen_nxt;
  logic                          ovf_r, ovf_nxt;

  logic                          first, row_full, hit, gt;
  logic [LOGIT_BITS:0]           up_d, dn_d, diff_w;

  always_comb begin
    first    = (count_r == '0);
    row_full = (count_r == CNT_W'(MAX_COLS));
    tgt_eff  = first ? target_class : tgt_r;
    hit      = !row_full && (CMP_W'(count_r) == CMP_W'(tgt_eff));
    gt       = (logit > max_r);
    up_d     = {logit[LOGIT_BITS-1], logit} - {max_r[LOGIT_BITS-1], max_r};
    dn_d     = {max_r[LOGIT_BITS-1], max_r} - {logit[LOGIT_BITS-1], logit};

    max_nxt   = max_r;
    count_nxt = count_r;
    if (!row_full) begin
      if (first || gt) begin
        max_nxt = logit;
      end
      count_nxt = count_r + 1'b1;
    end
    tval_nxt = hit ? logit : tval_r;
    seen_nxt = seen_r || hit;
    ovf_nxt  = ovf_r || row_full;
    diff_w   = {max_nxt[LOGIT_BITS-1], max_nxt} - {tval_nxt[LOGIT_BITS-1], tval_nxt};
  end

  always_comb begin
    if (row_full) begin
      ctl.op = cerl_pkg::OP_SKIP;
    end else if (first) begin
      ctl.op = cerl_pkg::OP_FIRST;
    end else if (gt) begin
      ctl.op = cerl_pkg::OP_RESCALE;
    end else begin
      ctl.op = cerl_pkg::OP_ACCUM;
    end
    ctl.last = last_in_row;
    if (ovf_nxt) begin
      ctl.status = cerl_pkg::ST_OVERFLOW;
    end else if (!seen_nxt) begin
      ctl.status = cerl_pkg::ST_NO_TARGET;
    end else begin
      ctl.status = cerl_pkg::ST_OK;
    end
    d    = gt ? up_d[LOGIT_BITS-1:0] : dn_d[LOGIT_BITS-1:0];
    diff = diff_w[LOGIT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= MOST_NEG;
      tval_r  <= '0;
      count_r <= '0;
      tgt_r   <= '0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (last_in_row) begin
        max_r   <= MOST_NEG;
        tval_r  <= '0;
        count_r <= '0;
        tgt_r   <= '0;
        seen_r  <= 1'b0;
        ovf_r   <= 1'b0;
      end else begin
        max_r   <= max_nxt;
        tval_r  <= tval_nxt;
        count_r <= count_nxt;
        tgt_r   <= tgt_eff;
        seen_r  <= seen_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CNT_W'(MAX_COLS)) else $error("overflow without full row");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_COLS)) else $error("column count beyond limit");

  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_in_row) |=> (count_r == '0 && !seen_r && !ovf_r))
    else $error("row state not cleared at row end");

endmodule

// ===== src/cerl_back.sv =====
module cerl_back #(
  parameter int unsigned LOGIT_BITS      = cerl_pkg::LOGIT_BITS_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = cerl_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  cerl_pkg::ctl_t                    q_ctl,
  input  logic [LOGIT_BITS-1:0]             q_d,
  input  logic [LOGIT_BITS-1:0]             q_diff,
  output logic                              q_pop,
  input  logic                              out_full,
  output logic                              res_valid,
  output logic [cerl_pkg::LOSS_W-1:0]       res_loss,
  output cerl_pkg::status_t                 res_status
);

  localparam int unsigned TERM_W = cerl_pkg::TERM_W;
  localparam int unsigned SUM_W  = cerl_pkg::SUM_W;
  localparam int unsigned LN_W   = cerl_pkg::LN_W;
  localparam int unsigned LOSS_W = cerl_pkg::LOSS_W;
  localparam int unsigned DW     = (LOGIT_BITS > 12) ? LOGIT_BITS : 13;
  localparam int unsigned KW     = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned KP_W   = 8 + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int unsigned LW     = ((LOGIT_BITS + 8 > LOSS_W) ? LOGIT_BITS + 8 : LOSS_W) + 1;

  logic [TERM_W-1:0]            iexp_tab [16];
  logic [TERM_W-1:0]            fexp_tab [EXP_TABLE_DEPTH];
  logic [cerl_pkg::LN_TAB_W-1:0] ln_tab  [256];

  for (genvar g = 0; g < 16; g++) begin : g_iexp
    localparam logic [TERM_W-1:0] V = cerl_pkg::iexp_entry(g);
    assign iexp_tab[g] = V;
  end

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_fexp
    localparam logic [TERM_W-1:0] V = cerl_pkg::fexp_entry(g, EXP_TABLE_DEPTH);
    assign fexp_tab[g] = V;
  end

  for (genvar g = 0; g < 256; g++) begin : g_ln
    localparam logic [cerl_pkg::LN_TAB_W-1:0] V = cerl_pkg::ln_entry(g);
    assign ln_tab[g] = V;
  end

  logic run;
  assign run   = !out_full;
  assign q_pop = run && !q_empty;

  // term lookup and product
  logic [DW-1:0]     d_ext;
  logic              d_big;
  logic [KP_W-1:0]   k_prod;
  logic [KW-1:0]     k_idx;
  logic [2*TERM_W-1:0] t_prod;
  logic [TERM_W-1:0] term;

  always_comb begin
    d_ext  = DW'(q_d);
    d_big  = |d_ext[DW-1:12];
    k_prod = KP_W'(d_ext[7:0]) * KP_W'(EXP_TABLE_DEPTH);
    k_idx  = k_prod[8 +: KW];
    t_prod = (2*TERM_W)'(iexp_tab[d_ext[11:8]]) * (2*TERM_W)'(fexp_tab[k_idx])
           + (2*TERM_W)'(32768);
    term   = d_big ? '0 : t_prod[16 +: TERM_W];
  end

  logic                  s1_v_r;
  cerl_pkg::ctl_t        s1_ctl_r;
  logic [TERM_W-1:0]     s1_term_r;
  logic [LOGIT_BITS-1:0] s1_diff_r;

  // running sum
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [SUM_W:0]            acc_w;
  logic [SUM_W+TERM_W-1:0]   mul_w;
  logic [SUM_W+1:0]          resc_w;

  always_comb begin
    acc_w  = {1'b0, sum_r} + (SUM_W + 1)'(s1_term_r);
    mul_w  = (SUM_W + TERM_W)'(sum_r) * (SUM_W + TERM_W)'(s1_term_r)
           + (SUM_W + TERM_W)'(32768);
    resc_w = (SUM_W + 2)'(mul_w[SUM_W+TERM_W-1:16]) + (SUM_W + 2)'(cerl_pkg::Q16_ONE);
    sum_nxt = sum_r;
    if (s1_v_r) begin
      case (s1_ctl_r.op)
        cerl_pkg::OP_FIRST:   sum_nxt = SUM_W'(cerl_pkg::Q16_ONE);
        cerl_pkg::OP_RESCALE: sum_nxt = (|resc_w[SUM_W+1:SUM_W]) ? '1 : resc_w[SUM_W-1:0];
        cerl_pkg::OP_ACCUM:   sum_nxt = acc_w[SUM_W] ? '1 : acc_w[SUM_W-1:0];
        default:              sum_nxt = sum_r;
      endcase
    end
  end

  logic                  s2_v_r;
  cerl_pkg::status_t     s2_status_r;
  logic [LOGIT_BITS-1:0] s2_diff_r;

  // leading one of the final sum
  logic       tiny;
  logic [3:0] pe;

  always_comb begin
    tiny = (sum_r[SUM_W-1:16] == '0);
    pe   = '0;
    for (int i = 0; i < 16; i++) begin
      if (sum_r[16 + i]) begin
        pe = 4'(i);
      end
    end
  end

  logic                  s3_v_r;
  cerl_pkg::status_t     s3_status_r;
  logic [LOGIT_BITS-1:0] s3_diff_r;
  logic [SUM_W-1:0]      s3_sum_r;
  logic [3:0]            s3_pe_r;
  logic                  s3_tiny_r;

  // ln of the sum
  logic [SUM_W-1:0] shv;
  logic [LN_W-1:0]  ln;

  always_comb begin
    shv = s3_sum_r >> ({1'b0, s3_pe_r} + 5'd8);
    ln  = LN_W'(s3_pe_r) * cerl_pkg::LN2_Q16 + LN_W'(ln_tab[shv[7:0]]);
    if (s3_tiny_r) begin
      ln = '0;
    end
  end

  logic                  s4_v_r;
  cerl_pkg::status_t     s4_status_r;
  logic [LOGIT_BITS-1:0] s4_diff_r;
  logic [LN_W-1:0]       s4_ln_r;

  logic [LW-1:0] loss_w;

  always_comb begin
    loss_w     = LW'(s4_ln_r) + (LW'(s4_diff_r) << 8);
    res_valid  = s4_v_r && run;
    res_status = s4_status_r;
    if (s4_status_r != cerl_pkg::ST_OK || (|loss_w[LW-1:LOSS_W])) begin
      res_loss = '1;
    end else begin
      res_loss = loss_w[LOSS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      sum_r  <= '0;
    end else if (run) begin
      s1_v_r <= !q_empty;
      s2_v_r <= s1_v_r && s1_ctl_r.last;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      s1_ctl_r    <= q_ctl;
      s1_term_r   <= term;
      s1_diff_r   <= q_diff;
      s2_status_r <= s1_ctl_r.status;
      s2_diff_r   <= s1_diff_r;
      s3_status_r <= s2_status_r;
      s3_diff_r   <= s2_diff_r;
      s3_sum_r    <= sum_r;
      s3_pe_r     <= pe;
      s3_tiny_r   <= tiny;
      s4_status_r <= s3_status_r;
      s4_diff_r   <= s3_diff_r;
      s4_ln_r     <= ln;
    end
  end

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> s1_term_r <= cerl_pkg::Q16_ONE) else $error("exp term above one");

  a_row_sum: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> sum_r[SUM_W-1:16] != '0) else $error("row sum below one at row end");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !run |=> $stable(sum_r)) else $error("sum moved during stall");

endmodule

// ===== bench/cerl_checker.sv =====
`timescale 1ns / 1ps
module cerl_checker (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_push,
  input  logic                                       in_full,
  input  logic signed [cerl_pkg::LOGIT_BITS_DEF-1:0] in_logit,
  input  logic [cerl_pkg::TARGET_W-1:0]              in_target_class,
  input  logic                                       in_last_in_row,
  input  logic                                       out_empty,
  input  logic                                       out_pop,
  input  logic [cerl_pkg::LOSS_W-1:0]                out_loss,
  input  logic [cerl_pkg::STATUS_W-1:0]              out_status,
  output int                                         fail_count,
  output int                                         pending
);

  localparam int unsigned NCOLS = cerl_pkg::MAX_COLS_DEF;
  localparam int unsigned DEPTH = cerl_pkg::EXP_TABLE_DEPTH_DEF;
  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned SUM_SAT = 64'hFFFF_FFFF;
  localparam logic [cerl_pkg::LOSS_W-1:0] LOSS_SAT = '1;

  typedef struct packed {
    logic [cerl_pkg::LOSS_W-1:0] loss;
    cerl_pkg::status_t           status;
  } row_result_t;

  longint unsigned int_exp[16];
  longint unsigned frac_exp[DEPTH];
  longint unsigned log_mant[256];

  int              row_max;
  int              tgt_logit;
  longint unsigned row_sum;
  int unsigned     ncols;
  int unsigned     tgt_col;
  bit              tgt_hit;
  bit              too_long;

  row_result_t loss_q[$];
  int          errs = 0;

  // exp(-x) for x in [0,1], Q30
  function automatic longint unsigned series_exp_neg(input longint unsigned x);
    longint unsigned t;
    longint          acc;
    t = ONE30;
    acc = longint'(ONE30);
    for (int unsigned i = 1; i <= 20; i++) begin
      t = ((t * x) >> 30) / i;
      if (i % 2 == 1) acc -= longint'(t);
      else acc += longint'(t);
    end
    if (acc < 0) acc = 0;
    return longint'(acc);
  endfunction

  function automatic longint unsigned exp_q16(input longint unsigned d);
    longint unsigned n;
    longint unsigned k;
    n = d >> 8;
    if (n >= 16) return 0;
    k = ((d & 255) * DEPTH) >> 8;
    if (k >= DEPTH) k = DEPTH - 1;
    return (int_exp[n] * frac_exp[k] + 32768) >> 16;
  endfunction

  function automatic longint log_q16(input longint unsigned s);
    int              p;
    longint unsigned j;
    if (s < 65536) return 0;
    p = 31;
    while (p > 16 && s[p] == 1'b0) p--;
    j = (s >> (p - 8)) & 255;
    return longint'(p - 16) * longint'(cerl_pkg::LN2_Q16) + longint'(log_mant[j]);
  endfunction

  function automatic longint unsigned sat32(input longint unsigned s);
    return (s > SUM_SAT) ? SUM_SAT : s;
  endfunction

  task automatic clear_row();
    row_max   = -(1 << (cerl_pkg::LOGIT_BITS_DEF - 1));
    row_sum   = 0;
    tgt_logit = 0;
    ncols     = 0;
    tgt_col   = 0;
    tgt_hit   = 1'b0;
    too_long  = 1'b0;
  endtask

  task automatic absorb_logit(input int x, input int unsigned tc, input bit last,
                              output bit done, output row_result_t res);
    longint unsigned d;
    longint unsigned s;
    longint          l;
    done = 1'b0;
    res  = '0;
    if (ncols == 0 && !too_long) tgt_col = tc;
    if (ncols >= NCOLS) begin
      too_long = 1'b1;
    end else begin
      if (ncols == 0) begin
        row_max = x;
        row_sum = 65536;
      end else if (x > row_max) begin
        d = x - row_max;
        s = ((row_sum * exp_q16(d) + 32768) >> 16) + 65536;
        row_sum = sat32(s);
        row_max = x;
      end else begin
        d = row_max - x;
        row_sum = sat32(row_sum + exp_q16(d));
      end
      if (ncols == tgt_col) begin
        tgt_logit = x;
        tgt_hit   = 1'b1;
      end
      ncols++;
    end
    if (!last) return;
    done = 1'b1;
    if (too_long) begin
      res.loss   = LOSS_SAT;
      res.status = cerl_pkg::ST_OVERFLOW;
    end else if (!tgt_hit) begin
      res.loss   = LOSS_SAT;
      res.status = cerl_pkg::ST_NO_TARGET;
    end else begin
      l = log_q16(row_sum) + longint'(row_max - tgt_logit) * 256;
      if (l < 0) l = 0;
      if (l > longint'(LOSS_SAT)) l = longint'(LOSS_SAT);
      res.loss   = l[cerl_pkg::LOSS_W-1:0];
      res.status = cerl_pkg::ST_OK;
    end
    clear_row();
  endtask

  initial begin
    longint unsigned e1;
    longint unsigned v;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned acc;
    e1 = series_exp_neg(ONE30);
    v  = ONE30;
    for (int n = 0; n < 16; n++) begin
      int_exp[n] = (v + (64'd1 << 13)) >> 14;
      v = (v * e1 + (64'd1 << 29)) >> 30;
    end
    for (int unsigned k = 0; k < DEPTH; k++) begin
      frac_exp[k] = (series_exp_neg((longint'(k) << 30) / DEPTH) + (64'd1 << 13)) >> 14;
    end
    for (int unsigned j = 0; j < 256; j++) begin
      z   = (longint'(j) << 30) / (512 + j);
      z2  = (z * z) >> 30;
      p   = z;
      acc = 0;
      for (int unsigned m = 0; m < 16; m++) begin
        acc += p / (2 * m + 1);
        p = (p * z2) >> 30;
      end
      log_mant[j] = (2 * acc + (64'd1 << 13)) >> 14;
    end
  end

  always @(posedge clk) begin
    bit          done;
    row_result_t res;
    row_result_t want;
    if (!rst_n) begin
      clear_row();
      loss_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (loss_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got loss %h status %0d",
                   $time, out_loss, out_status);
          errs++;
        end else begin
          want = loss_q.pop_front();
          if (want.loss !== out_loss) begin
            $display("%0t: loss expected %h got %h", $time, want.loss, out_loss);
            errs++;
          end
          if (want.status !== out_status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            errs++;
          end
        end
      end
      if (in_push && !in_full) begin
        absorb_logit(int'(in_logit), in_target_class, in_last_in_row, done, res);
        if (done) loss_q.push_back(res);
      end
    end
    fail_count <= errs;
    pending    <= loss_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int LW       = cerl_pkg::LOGIT_BITS_DEF;
  localparam int NCOLS_TB = cerl_pkg::MAX_COLS_DEF;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_push = 1'b0;
  logic                          in_full;
  logic signed [LW-1:0]          in_logit = '0;
  logic [cerl_pkg::TARGET_W-1:0] in_target_class = '0;
  logic                          in_last_in_row = 1'b0;
  logic                          out_empty;
  logic                          out_pop = 1'b0;
  logic [cerl_pkg::LOSS_W-1:0]   out_loss;
  logic [cerl_pkg::STATUS_W-1:0] out_status;
  int                            fail_count;
  int                            pending;
  bit                            calm = 1'b0;

  always #1 clk = ~clk;

  cross_entropy_row_loss_core DUT (.*);
  cerl_checker u_check (.*);

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 9));
  endfunction

  task automatic push_item(input int lg, input int unsigned tc, input bit last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_logit        <= lg[LW-1:0];
    in_target_class <= tc[cerl_pkg::TARGET_W-1:0];
    in_last_in_row  <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_row(input int len, input int unsigned tgt, input bit narrow);
    int base;
    int lg;
    base = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < len; i++) begin
      if (narrow) begin
        lg = base + int'($urandom_range(0, 1535)) - 768;
        if (lg > 32767) lg = 32767;
        if (lg < -32768) lg = -32768;
      end else begin
        lg = int'($urandom_range(0, 65535)) - 32768;
      end
      push_item(lg, (i == 0) ? tgt : $urandom_range(0, 65535), i == len - 1);
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  initial begin
    int          n;
    int          len;
    int          sel;
    int unsigned tgt;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-logit rows, target inside and outside
    push_item(32767, 0, 1);
    push_item(-32768, 1, 1);
    // rising max far beyond the exp table, then falling
    push_item(-32768, 1, 0);
    push_item(32767, 7, 1);
    push_item(32767, 1, 0);
    push_item(-32768, 0, 1);
    // equal logits
    push_item(0, 2, 0);
    push_item(0, 0, 0);
    push_item(0, 0, 1);
    // largest target class, never reached
    push_item(256, 65535, 0);
    push_item(-1, 0, 0);
    push_item(4095, 0, 1);
    // difference of exactly 16.0, term underflows to zero
    push_item(-4096, 1, 0);
    push_item(0, 0, 0);
    push_item(1, 0, 1);
    push_item(21845, 2, 0);
    push_item(-21846, 0, 0);
    push_item(21845, 0, 1);
    drain();

    // row one past the column limit, back to back, target never reached
    calm = 1'b1;
    send_row(NCOLS_TB + 1, 65535, 1'b1);
    calm = 1'b0;
    drain();

    n = 0;
    while (n < 450) begin
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(17, 64))
                                        : int'($urandom_range(1, 16));
      sel = $urandom_range(0, 9);
      if (sel < 8) tgt = $urandom_range(0, len - 1);
      else if (sel == 8) tgt = len + $urandom_range(0, 3);
      else tgt = $urandom_range(0, 65535);
      calm = ($urandom_range(0, 7) == 0);
      send_row(len, tgt, $urandom_range(0, 3) != 0);
      n += len;
    end
    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cerl_pkg.sv
src/cerl_queue.sv
src/cerl_front.sv
src/cerl_back.sv
src/cross_entropy_row_loss_core.sv
bench/cerl_checker.sv
bench/tb.sv
